[rtl/core/bmse_pkg.sv]
// ----------------------------------------------------------------------------
// bmse_pkg
// Shared types and constants for the batch machine schedule evaluator.
// ----------------------------------------------------------------------------
package bmse_pkg;

    // time format and batch limits
    localparam int TIME_FRAC_BITS = 8;
    localparam int MAX_BATCH_JOBS = 255;
    localparam int JOB_LIMIT      = (MAX_BATCH_JOBS < 255) ? MAX_BATCH_JOBS : 255;
    localparam int SH_UP          = (TIME_FRAC_BITS >= 8) ? TIME_FRAC_BITS - 8 : 0;
    localparam int SH_DN          = (TIME_FRAC_BITS >= 8) ? 0 : 8 - TIME_FRAC_BITS;
    localparam int DUR_W          = 40;

    // register indexes
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_INV_SPD  = 2'd1;
    localparam logic [1:0] REG_ENERGY   = 2'd2;

    // reset values
    localparam logic [9:0]  CAPACITY_RST = 10'd1023;
    localparam logic [15:0] INV_SPD_RST  = 16'd256;
    localparam logic [15:0] ENERGY_RST   = 16'd1;
    localparam logic signed [32:0] PEAK_RST = {1'b1, 32'd0};

    // closed batch record passed from front to back
    typedef struct packed {
        logic [7:0]  count;
        logic [15:0] max_proc;
        logic [31:0] max_release;
        logic [31:0] min_due;
        logic        oversize;
        logic        is_final;
        logic        has_batch;
        logic        last;
    } batch_rec_t;

endpackage

[rtl/core/bmse_queue.sv]
// ----------------------------------------------------------------------------
// bmse_queue
// Four-word queue between packing front and timing back; takes up to two
// words per cycle and hands out one.
// ----------------------------------------------------------------------------
module bmse_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push0,
    input  logic                 push1,
    input  bmse_pkg::batch_rec_t wdata0,
    input  bmse_pkg::batch_rec_t wdata1,
    output logic                 two_free,
    output logic                 not_empty,
    output bmse_pkg::batch_rec_t rdata,
    input  logic                 pop
);

    bmse_pkg::batch_rec_t mem [4];
    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] cnt_reg;
    logic [1:0] n_push;

    assign n_push    = {1'b0, push0} + {1'b0, push1};
    assign two_free  = (cnt_reg <= 3'd2);
    assign not_empty = (cnt_reg != 3'd0);
    assign rdata     = mem[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wptr_reg] <= wdata0;
        end
        if (push1)
        begin
            mem[wptr_reg + 2'd1] <= wdata1;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + n_push;
            if (pop)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {1'b0, n_push} - {2'b0, pop};
        end
    end

endmodule

[rtl/core/bmse_front.sv]
// ----------------------------------------------------------------------------
// bmse_front
// Packs jobs next-fit into the open batch and issues closed batch records.
// ----------------------------------------------------------------------------
module bmse_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [9:0]           job_size,
    input  logic [15:0]          job_proc_time,
    input  logic [31:0]          job_release,
    input  logic [31:0]          job_due,
    input  logic                 last_job,
    input  logic [9:0]           capacity,
    input  logic                 cap_write,
    input  logic [9:0]           cap_value,
    output logic                 push0,
    output logic                 push1,
    output bmse_pkg::batch_rec_t rec0,
    output bmse_pkg::batch_rec_t rec1
);

    logic [9:0]  room_reg,   room_next;
    logic [7:0]  cnt_reg,    cnt_next;
    logic [15:0] proc_reg,   proc_next;
    logic [31:0] rel_reg,    rel_next;
    logic [31:0] due_reg,    due_next;
    logic        over_reg,   over_next;

    logic        fits;
    logic        need_close;
    bmse_pkg::batch_rec_t close_rec;
    bmse_pkg::batch_rec_t final_rec;

    // packing decision
    always_comb
    begin
        fits       = (job_size <= capacity);
        need_close = fits && (cnt_reg != 8'd0) &&
                     ((job_size > room_reg) || (cnt_reg >= 8'(bmse_pkg::JOB_LIMIT)));

        close_rec.count       = cnt_reg;
        close_rec.max_proc    = proc_reg;
        close_rec.max_release = rel_reg;
        close_rec.min_due     = due_reg;
        close_rec.oversize    = over_reg;
        close_rec.is_final    = 1'b0;
        close_rec.has_batch   = 1'b1;
        close_rec.last        = !last_job;

        room_next = room_reg;
        cnt_next  = cnt_reg;
        proc_next = proc_reg;
        rel_next  = rel_reg;
        due_next  = due_reg;
        over_next = over_reg;

        if (!fits)
        begin
            over_next = 1'b1;
        end
        else
        begin
            if (need_close)
            begin
                room_next = capacity;
                cnt_next  = '0;
                proc_next = '0;
                rel_next  = '0;
                due_next  = '1;
            end
            room_next = room_next - job_size;
            cnt_next  = cnt_next + 8'd1;
            if (job_proc_time > proc_next) proc_next = job_proc_time;
            if (job_release > rel_next)    rel_next  = job_release;
            if (job_due < due_next)        due_next  = job_due;
        end

        final_rec.count       = cnt_next;
        final_rec.max_proc    = proc_next;
        final_rec.max_release = rel_next;
        final_rec.min_due     = due_next;
        final_rec.oversize    = over_next;
        final_rec.is_final    = 1'b1;
        final_rec.has_batch   = (cnt_next != 8'd0);
        final_rec.last        = 1'b1;

        push0 = accept && (need_close || last_job);
        push1 = accept && need_close && last_job;
        rec0  = need_close ? close_rec : final_rec;
        rec1  = final_rec;
    end

    // open batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            room_reg <= bmse_pkg::CAPACITY_RST;
            cnt_reg  <= '0;
            proc_reg <= '0;
            rel_reg  <= '0;
            due_reg  <= '1;
            over_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_job)
            begin
                room_reg <= capacity;
                cnt_reg  <= '0;
                proc_reg <= '0;
                rel_reg  <= '0;
                due_reg  <= '1;
                over_reg <= 1'b0;
            end
            else
            begin
                room_reg <= room_next;
                cnt_reg  <= cnt_next;
                proc_reg <= proc_next;
                rel_reg  <= rel_next;
                due_reg  <= due_next;
                over_reg <= over_next;
            end
        end
        else if (cap_write && (cnt_reg == 8'd0))
        begin
            room_reg <= cap_value;
        end
    end

endmodule

[rtl/core/bmse_back.sv]
// ----------------------------------------------------------------------------
// bmse_back
// Times each closed batch: duration, start, completion, tardiness and cost,
// keeps the running totals and drives the result word.
// ----------------------------------------------------------------------------
module bmse_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_avail,
    input  bmse_pkg::batch_rec_t rec,
    output logic                 pop,
    input  logic [15:0]          inv_speed,
    input  logic [15:0]          energy,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [15:0]          out_batch_number,
    output logic [7:0]           out_batch_jobs,
    output logic [31:0]          out_batch_start,
    output logic [31:0]          out_batch_completion,
    output logic signed [32:0]   out_batch_tardiness,
    output logic                 out_is_final,
    output logic [47:0]          out_total_cost,
    output logic signed [32:0]   out_max_tardiness,
    output logic                 out_oversize,
    output logic                 out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DUR  = 2'd1;
    localparam logic [1:0] ST_TIME = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]           state_reg;
    bmse_pkg::batch_rec_t rec_reg;
    logic [31:0]          dur_reg;
    logic [31:0]          start_reg;
    logic [31:0]          comp_reg;
    logic signed [32:0]   tard_reg;
    logic [39:0]          cj_reg;
    logic [31:0]          prev_reg;
    logic [15:0]          bnum_reg;
    logic [47:0]          sum_reg;
    logic signed [32:0]   peak_reg;

    logic [31:0]                   prod;
    logic [bmse_pkg::DUR_W-1:0]    scaled;
    logic [31:0]                   dur_sat;
    logic [31:0]                   start_c;
    logic [32:0]                   comp_w;
    logic [31:0]                   comp_c;
    logic [33:0]                   tard_w;
    logic [55:0]                   cost;
    logic [56:0]                   sum_w;
    logic [47:0]                   sum_c;
    logic signed [32:0]            peak_c;

    assign pop = (state_reg == ST_IDLE) && rec_avail;

    // duration: proc times inverse speed, rescaled and saturated
    always_comb
    begin
        prod    = {16'd0, rec_reg.max_proc} * {16'd0, inv_speed};
        scaled  = (bmse_pkg::DUR_W'(prod) << bmse_pkg::SH_UP) >> bmse_pkg::SH_DN;
        dur_sat = (|scaled[bmse_pkg::DUR_W-1:32]) ? '1 : scaled[31:0];
    end

    // start, completion and tardiness
    always_comb
    begin
        start_c = (prev_reg > rec_reg.max_release) ? prev_reg : rec_reg.max_release;
        comp_w  = {1'b0, start_c} + {1'b0, dur_reg};
        comp_c  = comp_w[32] ? '1 : comp_w[31:0];
        tard_w  = {2'b0, comp_c} - {2'b0, rec_reg.min_due};
    end

    // energy cost and totals
    always_comb
    begin
        cost   = cj_reg * {40'd0, energy};
        sum_w  = {9'd0, sum_reg} + {1'b0, cost};
        sum_c  = (|sum_w[56:48]) ? '1 : sum_w[47:0];
        peak_c = (tard_reg > peak_reg) ? tard_reg : peak_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
            prev_reg  <= '0;
            bnum_reg  <= 16'd1;
            sum_reg   <= '0;
            peak_reg  <= bmse_pkg::PEAK_RST;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (rec_avail)
                    begin
                        state_reg <= ST_DUR;
                    end
                end
                ST_DUR:
                begin
                    state_reg <= ST_TIME;
                end
                ST_TIME:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        if (rec_reg.is_final)
                        begin
                            prev_reg <= '0;
                            bnum_reg <= 16'd1;
                            sum_reg  <= '0;
                            peak_reg <= bmse_pkg::PEAK_RST;
                        end
                        else if (rec_reg.has_batch)
                        begin
                            prev_reg <= comp_reg;
                            sum_reg  <= sum_c;
                            peak_reg <= peak_c;
                            if (bnum_reg != 16'hFFFF)
                            begin
                                bnum_reg <= bnum_reg + 16'd1;
                            end
                        end
                    end
                    else if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= rec;
        end
        if (state_reg == ST_DUR)
        begin
            dur_reg <= dur_sat;
        end
        if (state_reg == ST_TIME)
        begin
            start_reg <= start_c;
            comp_reg  <= comp_c;
            tard_reg  <= signed'(tard_w[32:0]);
            cj_reg    <= {32'd0, rec_reg.count} * {8'd0, dur_reg};
        end
        if ((state_reg == ST_OUT) && !out_valid)
        begin
            out_is_final <= rec_reg.is_final;
            out_oversize <= rec_reg.oversize;
            out_last     <= rec_reg.last;
            if (rec_reg.has_batch)
            begin
                out_batch_number     <= bnum_reg;
                out_batch_jobs       <= rec_reg.count;
                out_batch_start      <= start_reg;
                out_batch_completion <= comp_reg;
                out_batch_tardiness  <= tard_reg;
            end
            else
            begin
                out_batch_number     <= '0;
                out_batch_jobs       <= '0;
                out_batch_start      <= '0;
                out_batch_completion <= '0;
                out_batch_tardiness  <= '0;
            end
            if (rec_reg.is_final)
            begin
                out_total_cost    <= rec_reg.has_batch ? sum_c : sum_reg;
                out_max_tardiness <= rec_reg.has_batch ? peak_c : peak_reg;
            end
            else
            begin
                out_total_cost    <= '0;
                out_max_tardiness <= '0;
            end
        end
    end

endmodule

[rtl/core/batch_machine_schedule_eval.sv]
// ----------------------------------------------------------------------------
// batch_machine_schedule_eval
// Serial batch machine packing and schedule evaluation for one machine.
// ----------------------------------------------------------------------------
// Jobs are taken at one per cycle while the four-word batch queue has room
// for two words; packing is a combinational add and compare. Each closed
// batch then passes through the timing back end in order (queue pop, duration
// multiply, start, completion and cost multiply, totals and result word) plus
// any output stall, so a job that closes a batch is absorbed at batch rate,
// set by the back end's sequencer. Configuration writes are always ready.
module batch_machine_schedule_eval
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [9:0]          job_size,
    input  logic [15:0]         job_proc_time,
    input  logic [31:0]         job_release,
    input  logic [31:0]         job_due,
    input  logic                last_job,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_batch_number,
    output logic [7:0]          out_batch_jobs,
    output logic [31:0]         out_batch_start,
    output logic [31:0]         out_batch_completion,
    output logic signed [32:0]  out_batch_tardiness,
    output logic                out_is_final,
    output logic [47:0]         out_total_cost,
    output logic signed [32:0]  out_max_tardiness,
    output logic                out_oversize,
    output logic                out_last
);

    logic [9:0]  cap_reg;
    logic [15:0] inv_reg;
    logic [15:0] energy_reg;
    logic        cfg_we;
    logic        cap_we;
    logic        accept;
    logic        push0;
    logic        push1;
    logic        two_free;
    logic        q_avail;
    logic        pop;
    bmse_pkg::batch_rec_t rec0;
    bmse_pkg::batch_rec_t rec1;
    bmse_pkg::batch_rec_t q_rec;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign cap_we    = cfg_we && (cfg_index == bmse_pkg::REG_CAPACITY);
    assign in_ready  = two_free;
    assign accept    = in_valid && in_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= bmse_pkg::CAPACITY_RST;
            inv_reg    <= bmse_pkg::INV_SPD_RST;
            energy_reg <= bmse_pkg::ENERGY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bmse_pkg::REG_CAPACITY: cap_reg    <= cfg_data[9:0];
                bmse_pkg::REG_INV_SPD:  inv_reg    <= cfg_data;
                bmse_pkg::REG_ENERGY:   energy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // packing front
    bmse_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .job_size      (job_size),
        .job_proc_time (job_proc_time),
        .job_release   (job_release),
        .job_due       (job_due),
        .last_job      (last_job),
        .capacity      (cap_reg),
        .cap_write     (cap_we),
        .cap_value     (cfg_data[9:0]),
        .push0         (push0),
        .push1         (push1),
        .rec0          (rec0),
        .rec1          (rec1)
    );

    // batch queue
    bmse_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (push0),
        .push1     (push1),
        .wdata0    (rec0),
        .wdata1    (rec1),
        .two_free  (two_free),
        .not_empty (q_avail),
        .rdata     (q_rec),
        .pop       (pop)
    );

    // timing back end
    bmse_back u_back
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .rec_avail            (q_avail),
        .rec                  (q_rec),
        .pop                  (pop),
        .inv_speed            (inv_reg),
        .energy               (energy_reg),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .out_batch_number     (out_batch_number),
        .out_batch_jobs       (out_batch_jobs),
        .out_batch_start      (out_batch_start),
        .out_batch_completion (out_batch_completion),
        .out_batch_tardiness  (out_batch_tardiness),
        .out_is_final         (out_is_final),
        .out_total_cost       (out_total_cost),
        .out_max_tardiness    (out_max_tardiness),
        .out_oversize         (out_oversize),
        .out_last             (out_last)
    );

endmodule
